[rtl/smtpf_pkg.sv]
// Package for the SMTP body line framer: character constants, line state
// codes and the result pair handed to the output buffer. No dependencies.
`default_nettype none

package smtpf_pkg;

  localparam int unsigned RAW_W = 8;
  localparam int unsigned CHR_W = 7;

  localparam logic [RAW_W-1:0] RAW_CR = 8'd13;
  localparam logic [RAW_W-1:0] RAW_LF = 8'd10;

  localparam logic [CHR_W-1:0] CH_CR   = 7'd13;
  localparam logic [CHR_W-1:0] CH_LF   = 7'd10;
  localparam logic [CHR_W-1:0] CH_DOT  = 7'd46;
  localparam logic [CHR_W-1:0] CH_NUL  = 7'd0;
  localparam logic [RAW_W-1:0] MASK7   = 8'd127;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Line state, one-hot.
  typedef enum logic [3:0] {
    MODE_START = 4'b0001,
    MODE_RUN   = 4'b0010,
    MODE_LINE  = 4'b0100,
    MODE_TRUNC = 4'b1000
  } mode_t;

  // Results caused by one item: count is 0, 1 or 2; first goes out first.
  typedef struct packed {
    logic [1:0]       count;
    logic [CHR_W-1:0] first;
    logic [CHR_W-1:0] second;
  } pair_t;

endpackage

`default_nettype wire

[rtl/smtpf_if.sv]
// Valid/ready channel interfaces for the framer: body items in, text out.
// Depends on smtpf_pkg for field widths.
`default_nettype none

interface smtpf_body_if import smtpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [RAW_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface smtpf_text_if import smtpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CHR_W-1:0] out_byte;
  logic             last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/smtpf_out_buf.sv]
// Result buffer: holds the zero to two characters of one item and sends them
// one per cycle while text.ready is high. Depends on smtpf_pkg and smtpf_if.
`default_nettype none

module smtpf_out_buf import smtpf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire pair_t        pair,
  output logic              load_ok,
  smtpf_text_if.source      text
);

  logic [1:0]       cnt;
  logic [CHR_W-1:0] head;
  logic [CHR_W-1:0] tail;
  logic             pop;

  assign pop        = text.valid && text.ready;
  assign text.valid = (cnt != 2'd0);
  assign text.out_byte = head;
  assign text.last  = (cnt == 2'd1);
  // Take a new pair once the held one is gone or its last character leaves now.
  assign load_ok    = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= pair.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= pair.first;
      tail <= pair.second;
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

`default_nettype wire

[rtl/smtp_body_line_framer.sv]
// SMTP body line framer, top level. An item's first text character shows
// in the cycle after its accept. Throughput: one item per cycle while the
// receiver is ready, if it yields at most one character; the two-entry
// result buffer holds off the next item until CRLF or a doubled dot is out.
// Reset (rst, synchronous) returns the line state to start of message and
// empties the result buffer. Depends on smtpf_pkg, smtpf_if, smtpf_out_buf.
`default_nettype none

module smtp_body_line_framer import smtpf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  smtpf_body_if.sink   body,
  smtpf_text_if.source text
);

  mode_t            mode;
  mode_t            mode_next;
  pair_t            pair;
  logic             load_ok;
  logic             accept;
  logic             term;
  logic [CHR_W-1:0] ch;

  assign body.ready = load_ok;
  assign accept     = body.valid && body.ready;

  // Line terminators are recognized on the raw byte only; 141 and 138 pass
  // through as masked characters inside the line.
  assign term = (body.data_byte == RAW_CR) || (body.data_byte == RAW_LF);
  assign ch   = CHR_W'(body.data_byte & MASK7);

  // Decode one item: the characters it yields and the next line state.
  always_comb begin
    mode_next   = mode;
    pair.count  = 2'd0;
    pair.first  = ch;
    pair.second = CH_LF;
    if (body.cmd == CMD_END) begin
      // Close a pending line, then return to start of message.
      mode_next = MODE_START;
      if ((mode == MODE_LINE) || (mode == MODE_TRUNC)) begin
        pair.count = 2'd2;
        pair.first = CH_CR;
      end
    end else begin
      unique case (mode)
        MODE_RUN: begin
          // Swallow the rest of a CR/LF run; a blank line vanishes here.
          if (!term) begin
            mode_next = (ch == CH_NUL) ? MODE_TRUNC : MODE_LINE;
            if (ch == CH_DOT) begin
              pair.count  = 2'd2;
              pair.second = CH_DOT;
            end else if (ch != CH_NUL) begin
              pair.count = 2'd1;
            end
          end
        end
        MODE_LINE: begin
          if (term) begin
            mode_next  = MODE_RUN;
            pair.count = 2'd2;
            pair.first = CH_CR;
          end else if (ch == CH_NUL) begin
            // Zero byte: drop the rest of this line.
            mode_next = MODE_TRUNC;
          end else begin
            pair.count = 2'd1;
          end
        end
        MODE_TRUNC: begin
          if (term) begin
            mode_next  = MODE_RUN;
            pair.count = 2'd2;
            pair.first = CH_CR;
          end
        end
        default: begin
          // Start of message: a leading run yields one empty line.
          if (term) begin
            mode_next  = MODE_RUN;
            pair.count = 2'd2;
            pair.first = CH_CR;
          end else begin
            mode_next = (ch == CH_NUL) ? MODE_TRUNC : MODE_LINE;
            if (ch == CH_DOT) begin
              pair.count  = 2'd2;
              pair.second = CH_DOT;
            end else if (ch != CH_NUL) begin
              pair.count = 2'd1;
            end
          end
        end
      endcase
    end
  end

  // Advance the line state on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  smtpf_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .pair    (pair),
    .load_ok (load_ok),
    .text    (text)
  );

  // An item is taken only when no earlier character would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!text.valid || (text.ready && text.last)))
    else $error("item accepted over pending text");

  // An end item always returns the framer to start of message.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && (body.cmd == CMD_END)) |=> (mode == MODE_START))
    else $error("end item did not reset line state");

  // A terminator on a pending line shows CR first, with LF still to come.
  a_line_crlf: assert property (@(posedge clk) disable iff (rst)
    (accept && (body.cmd == CMD_BYTE) && term && (mode == MODE_LINE))
    |=> (text.valid && (text.out_byte == CH_CR) && !text.last))
    else $error("line terminator did not start CRLF");

endmodule

`default_nettype wire

[tb/tb_smtp_body_line_framer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for smtp_body_line_framer: body items in, predicted
// SMTP text characters checked in order. Depends on smtpf_pkg, smtpf_if, RTL.

module tb_smtp_body_line_framer;
  import smtpf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_NS     = 5_000_000;
  localparam int unsigned SHOW_ERRORS  = 10;

  // One framed character as it should leave the block.
  typedef struct packed {
    logic [CHR_W-1:0] ch;
    logic             last;
  } text_chr_t;

  // Receiver stall patterns.
  typedef enum int unsigned {
    RX_OPEN,    // always ready
    RX_COIN,    // ready on a coin toss
    RX_COMB,    // ready low on a repeating counter pattern
    RX_STARVE   // mostly stalled
  } rx_style_t;

  // Line framing predictor plus the queue of characters still owed by the block.
  class framer_scoreboard;
    mode_t       line_st;
    text_chr_t   text_due[$];
    int unsigned errors;

    function new();
      line_st = MODE_START;
      errors  = 0;
    endfunction

    function void due(logic [CHR_W-1:0] ch, logic last);
      text_chr_t t;
      t.ch   = ch;
      t.last = last;
      text_due.push_back(t);
    endfunction

    function void due_crlf();
      due(CH_CR, 1'b0);
      due(CH_LF, 1'b1);
    endfunction

    // First character of a fresh line: a zero opens an empty truncated line,
    // a dot goes out twice.
    function void open_line(logic [CHR_W-1:0] ch);
      if (ch == CH_NUL) begin
        line_st = MODE_TRUNC;
      end else begin
        line_st = MODE_LINE;
        if (ch == CH_DOT) begin
          due(CH_DOT, 1'b0);
          due(CH_DOT, 1'b1);
        end else begin
          due(ch, 1'b1);
        end
      end
    endfunction

    function void note_item(logic cmd, logic [RAW_W-1:0] raw);
      logic [CHR_W-1:0] ch;
      logic             term;
      ch   = raw[CHR_W-1:0];
      // Terminators are judged on the raw eight-bit value.
      term = (raw == RAW_CR) || (raw == RAW_LF);
      if (cmd == CMD_END) begin
        if (line_st == MODE_LINE || line_st == MODE_TRUNC) due_crlf();
        line_st = MODE_START;
      end else begin
        case (line_st)
          MODE_RUN: begin
            if (!term) open_line(ch);
          end
          MODE_LINE: begin
            if (term) begin
              line_st = MODE_RUN;
              due_crlf();
            end else if (ch == CH_NUL) begin
              line_st = MODE_TRUNC;
            end else begin
              due(ch, 1'b1);
            end
          end
          MODE_TRUNC: begin
            if (term) begin
              line_st = MODE_RUN;
              due_crlf();
            end
          end
          default: begin
            if (term) begin
              line_st = MODE_RUN;
              due_crlf();
            end else begin
              open_line(ch);
            end
          end
        endcase
      end
    endfunction

    function void check_text(logic [CHR_W-1:0] ch, logic last);
      text_chr_t want;
      if (text_due.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("unexpected text item: out_byte=%0d last=%0b", ch, last);
      end else begin
        want = text_due.pop_front();
        if (ch !== want.ch || last !== want.last) begin
          errors++;
          if (errors <= SHOW_ERRORS)
            $display("text mismatch: expected out_byte=%0d last=%0b, got out_byte=%0d last=%0b",
                     want.ch, want.last, ch, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  smtpf_body_if body ();
  smtpf_text_if text ();

  smtp_body_line_framer u_dut (
    .clk  (clk),
    .rst  (rst),
    .body (body),
    .text (text)
  );

  framer_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #LIMIT_NS;
    $display("Regression FAIL");
    $finish;
  end

  // Check every character the receiver takes.
  always @(posedge clk) begin
    if (!rst && text.valid && text.ready) sb.check_text(text.out_byte, text.last);
  end

  // Receiver: switch between randomly chosen stall patterns.
  initial begin
    rx_style_t   style;
    int unsigned left;
    int unsigned cyc;
    text.ready = 1'b0;
    style      = RX_OPEN;
    left       = 0;
    cyc        = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (left == 0) begin
        style = rx_style_t'($urandom_range(0, 3));
        left  = $urandom_range(16, 160);
      end
      case (style)
        RX_OPEN:  text.ready = 1'b1;
        RX_COIN:  text.ready = 1'($urandom);
        RX_COMB:  text.ready = (cyc % 5) != 0;
        default:  text.ready = ($urandom_range(0, 7) == 0);
      endcase
      left--;
      cyc++;
      @(negedge clk);
    end
  end

  // Hand one item to the block. Called at a falling edge; returns at the
  // falling edge after acceptance. Insert an idle gap when a burst runs out.
  task automatic send_item(input logic cmd, input logic [RAW_W-1:0] raw);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
      body.valid = 1'b0;
      repeat (gap) begin
        @(negedge clk);
        // Junk on the payload while idle must not matter.
        body.cmd       = 1'($urandom);
        body.data_byte = 8'($urandom);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
    end
    body.valid     = 1'b1;
    body.cmd       = cmd;
    body.data_byte = raw;
    do @(posedge clk); while (!body.ready);
    sb.note_item(cmd, raw);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Body character with bias toward printable text and the corner values.
  function automatic logic [RAW_W-1:0] pick_char();
    case ($urandom_range(0, 19))
      0:       return {1'($urandom), CH_NUL};
      1:       return 8'd141;
      2:       return 8'd138;
      3:       return 8'($urandom);
      default: return {1'($urandom), 7'($urandom_range(32, 126))};
    endcase
  endfunction

  // Run of CR and LF bytes.
  task automatic send_run();
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n) send_item(CMD_BYTE, $urandom_range(0, 1) ? RAW_CR : RAW_LF);
  endtask

  // Well-formed message: lines of random text, optional leading run, last line
  // sometimes left open, then the end item.
  task automatic send_mail();
    int unsigned lines;
    int unsigned len;
    lines = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) send_run();
    for (int unsigned i = 0; i < lines; i++) begin
      len = $urandom_range(0, 12);
      for (int unsigned j = 0; j < len; j++) begin
        if (j == 0 && $urandom_range(0, 3) == 0)
          send_item(CMD_BYTE, $urandom_range(0, 1) ? 8'h2E : 8'hAE);
        else
          send_item(CMD_BYTE, pick_char());
      end
      if (i + 1 < lines || $urandom_range(0, 1)) send_run();
    end
    send_item(CMD_END, 8'($urandom));
  endtask

  // Raw noise: any byte, stray end items.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 20);
    repeat (n) send_item(($urandom_range(0, 7) == 0) ? CMD_END : CMD_BYTE, 8'($urandom));
  endtask

  initial begin
    int unsigned goal;
    rst            = 1'b1;
    body.valid     = 1'b0;
    body.cmd       = CMD_BYTE;
    body.data_byte = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message.
    send_item(CMD_END, 8'h00);
    // Leading run gives one empty line; the LF after it is absorbed.
    send_item(CMD_BYTE, RAW_CR);
    send_item(CMD_BYTE, RAW_LF);
    // Dot at line start doubled, later dots (plain and masked) single.
    send_item(CMD_BYTE, 8'h2E);
    send_item(CMD_BYTE, 8'h2E);
    send_item(CMD_BYTE, 8'hAE);
    // High-bit CR and LF are not terminators: sent as 13 and 10 in the line.
    send_item(CMD_BYTE, 8'd141);
    send_item(CMD_BYTE, 8'd138);
    send_item(CMD_BYTE, RAW_LF);
    // Masked dot at line start doubled.
    send_item(CMD_BYTE, 8'hAE);
    // Zero truncates: drop the rest until the terminator.
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h78);
    send_item(CMD_BYTE, 8'd141);
    send_item(CMD_BYTE, RAW_CR);
    // Masked zero at line start: empty pending line, closed by the end item.
    send_item(CMD_BYTE, 8'h80);
    send_item(CMD_END, 8'h00);
    // Extremes of the byte range, end with an ignored payload.
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h01);
    send_item(CMD_END, 8'hFF);
    // Body ending in a run: the end item yields nothing.
    send_item(CMD_BYTE, 8'h41);
    send_item(CMD_BYTE, RAW_CR);
    send_item(CMD_BYTE, RAW_LF);
    send_item(CMD_BYTE, RAW_CR);
    send_item(CMD_END, 8'h55);
    // Dot as the very first byte of a message.
    send_item(CMD_BYTE, 8'h2E);
    send_item(CMD_END, 8'h00);

    // Random: mostly well-formed messages, some noise.
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_mail();
    end
    body.valid = 1'b0;

    // Drain, then give stray characters a chance to show up.
    while (sb.text_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.text_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/smtpf_pkg.sv
rtl/smtpf_if.sv
rtl/smtpf_out_buf.sv
rtl/smtp_body_line_framer.sv
tb/tb_smtp_body_line_framer.sv
